FILE: hw/rtl/rpc_pkg.sv
package rpc_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int GUARD         = 8;

  localparam logic MODE_RECT  = 1'b0;
  localparam logic MODE_POLAR = 1'b1;

  // datapath widths
  localparam int AW    = 33;            // folded operand, holds the negated minimum
  localparam int XW    = 44;            // cordic x/y with guard bits and gain growth
  localparam int ZW    = 35;            // q30 angle accumulator
  localparam int RND_W = 38;            // rounded result before clipping

  // angle reduction: |b| << ANG_SHIFT modulo 2*pi, quotient by reciprocal
  localparam int ANG_SHIFT   = 30 - FRACTION_BITS;
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = 38 - FRACTION_BITS;
  localparam int QW          = 30 - FRACTION_BITS;
  localparam int TPW         = 33;
  localparam int RW          = TPW + 1;
  localparam int DW          = QW + TPW;
  localparam int PRW         = 32 + RECIP_W;

  localparam longint unsigned TWO_PI_Q30_U = 64'd6746518852;
  localparam longint unsigned RECIP_M =
      (64'd1 << (RECIP_SHIFT + ANG_SHIFT)) / TWO_PI_Q30_U;

  localparam logic [TPW-1:0]        TWO_PI_U   = TPW'(TWO_PI_Q30_U);
  localparam logic signed [ZW-1:0]  TWO_PI_Q30 = ZW'(64'sd6746518852);
  localparam logic signed [ZW-1:0]  PI_Q30     = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0]  HALF_PI_Q30 = ZW'(64'sd1686629713);

  // gain removal: v * 2547003 / 2^22, split so each product stays near 22 x 22
  localparam int SPLIT      = 22;
  localparam int GAIN_W     = 22;
  localparam int GAIN_SHIFT = 22 + GUARD;
  localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(2547003);
  localparam int PH_W = XW - SPLIT + GAIN_W + 1;
  localparam int PL_W = SPLIT + GAIN_W;
  localparam int PW   = XW + GAIN_W + 1;

  localparam logic signed [RND_W-1:0] S32_MAX = RND_W'(64'sd2147483647);
  localparam logic signed [RND_W-1:0] S32_MIN = RND_W'(-64'sd2147483648);

  typedef struct packed {
    logic               mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_a;
    logic signed [31:0] result_b;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic               mode;
    logic               zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } sat_t;

  // atan(2^-i) in q30, exact table for the first ten steps
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = ZW'(64'sd843314857);
      1:       r = ZW'(64'sd497837829);
      2:       r = ZW'(64'sd263043837);
      3:       r = ZW'(64'sd133525159);
      4:       r = ZW'(64'sd67021687);
      5:       r = ZW'(64'sd33543516);
      6:       r = ZW'(64'sd16775851);
      7:       r = ZW'(64'sd8388437);
      8:       r = ZW'(64'sd4194283);
      9:       r = ZW'(64'sd2097149);
      default: r = (i <= 30) ? ZW'(64'd1 << (30 - i)) : '0;
    endcase
    return r;
  endfunction

  function automatic sat_t sat32(input logic signed [RND_W-1:0] v);
    sat_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > S32_MAX) begin
      r.sat = 1'b1;
      r.val = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      r.sat = 1'b1;
      r.val = S32_MIN[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/rect_polar_converter.sv
// Rectangular/polar converter on a fully pipelined CORDIC. Mode 0 takes x,y and returns
// magnitude and atan2 angle; mode 1 takes radius and angle (any value, reduced modulo
// 2*pi) and returns x,y. Coordinates are signed Q15.16, angles Q15.16 radians, and a
// result clipped to 32 bits sets saturated. One request is taken every cycle while in_stall_o is
// low. The pipeline has four stages of operand folding and angle reduction, one stage per
// micro-rotation, three stages of gain removal, rounding and clipping, then the output
// register. A two-entry output buffer stops the pipeline only when both entries are held by a
// stalled consumer, which is the only time in_stall_o is raised.
module rect_polar_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rpc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rpc_pkg::out_t out_data_o
);

  logic          en;
  logic          prep_v, rot_v, last_v;
  rpc_pkg::rot_t prep_data, rot_data;
  rpc_pkg::out_t last_data;

  logic          out_v_q, out_v_d, skid_v_q, skid_v_d;
  rpc_pkg::out_t out_q, skid_q;
  logic          consume, out_take, load_last, load_skid, skid_load;

  // pipeline moves whenever the skid entry is free
  assign en         = ~skid_v_q;
  assign in_stall_o = skid_v_q;

  rpc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (prep_v),
    .data_o  (prep_data)
  );

  rpc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_v),
    .data_i  (prep_data),
    .valid_o (rot_v),
    .data_o  (rot_data)
  );

  rpc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rot_v),
    .data_i  (rot_data),
    .valid_o (last_v),
    .data_o  (last_data)
  );

  always_comb begin
    consume   = en & last_v;
    out_take  = out_v_q & ~out_stall_i;
    out_v_d   = out_v_q;
    skid_v_d  = skid_v_q;
    load_last = 1'b0;
    load_skid = 1'b0;
    skid_load = 1'b0;
    if (skid_v_q) begin
      if (out_take) begin
        load_skid = 1'b1;
        skid_v_d  = 1'b0;
      end
    end else if (consume) begin
      if (!out_v_q || out_take) begin
        load_last = 1'b1;
        out_v_d   = 1'b1;
      end else begin
        skid_load = 1'b1;
        skid_v_d  = 1'b1;
      end
    end else if (out_take) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_last) begin
      out_q <= last_data;
    end else if (load_skid) begin
      out_q <= skid_q;
    end
    if (skid_load) begin
      skid_q <= last_data;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without an output entry");

  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid entry filled while the output was free");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_stall_i) |=> !skid_v_q)
    else $error("skid entry not drained after the output was taken");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && skid_v_q))
    else $error("input stalled with buffer space free");

endmodule

FILE: hw/rtl/rpc_prep.sv
module rpc_prep (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rpc_pkg::in_t  data_i,
  output logic          valid_o,
  output rpc_pkg::rot_t data_o
);

  // stage 1: half-plane fold for rect, reciprocal multiply for polar
  logic                              s1_v_q;
  logic                              s1_mode_q, s1_zero_q, s1_bneg_q;
  logic signed [rpc_pkg::AW-1:0]     s1_a_q, s1_b_q;
  logic signed [rpc_pkg::ZW-1:0]     s1_z_q;
  logic [31:0]                       s1_babs_q;
  logic [rpc_pkg::PRW-1:0]           s1_prod_q;

  logic                              s1_zero_d, s1_bneg_d;
  logic signed [rpc_pkg::AW-1:0]     a_ext, b_ext, s1_a_d, s1_b_d;
  logic signed [rpc_pkg::ZW-1:0]     s1_z_d;
  logic [31:0]                       s1_babs_d;
  logic [rpc_pkg::PRW-1:0]           s1_prod_d;

  always_comb begin
    a_ext     = rpc_pkg::AW'(data_i.operand_a);
    b_ext     = rpc_pkg::AW'(data_i.operand_b);
    s1_zero_d = (data_i.operand_a == 32'sd0) && (data_i.operand_b == 32'sd0);
    s1_a_d    = a_ext;
    s1_b_d    = b_ext;
    s1_z_d    = '0;
    if ((data_i.mode == rpc_pkg::MODE_RECT) && (data_i.operand_a < 32'sd0)) begin
      s1_a_d = -a_ext;
      s1_b_d = -b_ext;
      s1_z_d = (data_i.operand_b >= 32'sd0) ? rpc_pkg::PI_Q30 : -rpc_pkg::PI_Q30;
    end
    s1_bneg_d = data_i.operand_b[31];
    s1_babs_d = s1_bneg_d ? (~data_i.operand_b + 32'd1) : data_i.operand_b;
    s1_prod_d = rpc_pkg::PRW'(s1_babs_d)
              * rpc_pkg::PRW'(rpc_pkg::RECIP_M[rpc_pkg::RECIP_W-1:0]);
  end

  // stage 2: remainder of |angle| against 2*pi, one short
  logic                              s2_v_q;
  logic                              s2_mode_q, s2_zero_q, s2_bneg_q;
  logic signed [rpc_pkg::AW-1:0]     s2_a_q, s2_b_q;
  logic signed [rpc_pkg::ZW-1:0]     s2_z_q;
  logic [rpc_pkg::RW-1:0]            s2_r_q;

  logic [rpc_pkg::QW-1:0]            quot;
  logic [rpc_pkg::DW-1:0]            zabs, qmul;
  logic [rpc_pkg::RW-1:0]            s2_r_d;

  always_comb begin
    quot   = s1_prod_q[rpc_pkg::RECIP_SHIFT +: rpc_pkg::QW];
    zabs   = rpc_pkg::DW'(s1_babs_q) << rpc_pkg::ANG_SHIFT;
    qmul   = rpc_pkg::DW'(quot) * rpc_pkg::DW'(rpc_pkg::TWO_PI_U);
    s2_r_d = rpc_pkg::RW'(zabs - qmul);
  end

  // stage 3: final correction, sign of the dividend
  logic                              s3_v_q;
  logic                              s3_mode_q, s3_zero_q;
  logic signed [rpc_pkg::AW-1:0]     s3_a_q, s3_b_q;
  logic signed [rpc_pkg::ZW-1:0]     s3_z_q;

  logic [rpc_pkg::TPW-1:0]           rem;
  logic signed [rpc_pkg::ZW-1:0]     zpos, s3_z_d;

  always_comb begin
    rem = (s2_r_q >= rpc_pkg::RW'(rpc_pkg::TWO_PI_U))
        ? rpc_pkg::TPW'(s2_r_q - rpc_pkg::RW'(rpc_pkg::TWO_PI_U))
        : rpc_pkg::TPW'(s2_r_q);
    zpos   = rpc_pkg::ZW'(rem);
    s3_z_d = (s2_mode_q == rpc_pkg::MODE_POLAR) ? (s2_bneg_q ? -zpos : zpos) : s2_z_q;
  end

  // stage 4: wrap into [-pi, pi], fold into the right half plane, load cordic
  logic                              s4_v_q;
  rpc_pkg::rot_t                     s4_q, s4_d;
  logic signed [rpc_pkg::ZW-1:0]     zw, zf;
  logic signed [rpc_pkg::AW-1:0]     a_n;

  always_comb begin
    zw = s3_z_q;
    if (s3_z_q > rpc_pkg::PI_Q30) begin
      zw = s3_z_q - rpc_pkg::TWO_PI_Q30;
    end else if (s3_z_q < -rpc_pkg::PI_Q30) begin
      zw = s3_z_q + rpc_pkg::TWO_PI_Q30;
    end
    zf  = zw;
    a_n = s3_a_q;
    if (zw > rpc_pkg::HALF_PI_Q30) begin
      zf  = zw - rpc_pkg::PI_Q30;
      a_n = -s3_a_q;
    end else if (zw < -rpc_pkg::HALF_PI_Q30) begin
      zf  = zw + rpc_pkg::PI_Q30;
      a_n = -s3_a_q;
    end
    s4_d.mode = s3_mode_q;
    s4_d.zero = s3_zero_q;
    if (s3_mode_q == rpc_pkg::MODE_POLAR) begin
      s4_d.x = rpc_pkg::XW'(a_n) <<< rpc_pkg::GUARD;
      s4_d.y = '0;
      s4_d.z = zf;
    end else begin
      s4_d.x = rpc_pkg::XW'(s3_a_q) <<< rpc_pkg::GUARD;
      s4_d.y = rpc_pkg::XW'(s3_b_q) <<< rpc_pkg::GUARD;
      s4_d.z = s3_z_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mode_q <= data_i.mode;
      s1_zero_q <= s1_zero_d;
      s1_bneg_q <= s1_bneg_d;
      s1_a_q    <= s1_a_d;
      s1_b_q    <= s1_b_d;
      s1_z_q    <= s1_z_d;
      s1_babs_q <= s1_babs_d;
      s1_prod_q <= s1_prod_d;

      s2_mode_q <= s1_mode_q;
      s2_zero_q <= s1_zero_q;
      s2_bneg_q <= s1_bneg_q;
      s2_a_q    <= s1_a_q;
      s2_b_q    <= s1_b_q;
      s2_z_q    <= s1_z_q;
      s2_r_q    <= s2_r_d;

      s3_mode_q <= s2_mode_q;
      s3_zero_q <= s2_zero_q;
      s3_a_q    <= s2_a_q;
      s3_b_q    <= s2_b_q;
      s3_z_q    <= s3_z_d;

      s4_q      <= s4_d;
    end
  end

  assign valid_o = s4_v_q;
  assign data_o  = s4_q;

endmodule

FILE: hw/rtl/rpc_cordic.sv
module rpc_cordic (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rpc_pkg::rot_t data_i,
  output logic          valid_o,
  output rpc_pkg::rot_t data_o
);

  logic [rpc_pkg::CORDIC_STEPS-1:0] v_q;
  logic [rpc_pkg::CORDIC_STEPS-1:0] v_in;
  rpc_pkg::rot_t                    st_q  [rpc_pkg::CORDIC_STEPS];
  rpc_pkg::rot_t                    st_in [rpc_pkg::CORDIC_STEPS];

  assign st_in[0] = data_i;
  assign v_in[0]  = valid_i;

  for (genvar k = 0; k < rpc_pkg::CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [rpc_pkg::ZW-1:0] ATAN_K = rpc_pkg::atan_q30(k);

    if (k > 0) begin : g_link
      assign st_in[k] = st_q[k-1];
      assign v_in[k]  = v_q[k-1];
    end

    rpc_pkg::rot_t                 nxt_d;
    logic                          sub;
    logic signed [rpc_pkg::XW-1:0] xs, ys;

    always_comb begin
      xs    = st_in[k].x >>> k;
      ys    = st_in[k].y >>> k;
      // vectoring drives y to zero, rotation drives z to zero
      sub   = (st_in[k].mode == rpc_pkg::MODE_RECT) ? st_in[k].y[rpc_pkg::XW-1]
                                                    : ~st_in[k].z[rpc_pkg::ZW-1];
      nxt_d = st_in[k];
      if (sub) begin
        nxt_d.x = st_in[k].x - ys;
        nxt_d.y = st_in[k].y + xs;
        nxt_d.z = st_in[k].z - ATAN_K;
      end else begin
        nxt_d.x = st_in[k].x + ys;
        nxt_d.y = st_in[k].y - xs;
        nxt_d.z = st_in[k].z + ATAN_K;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt_d;
      end
    end
  end

  assign valid_o = v_q[rpc_pkg::CORDIC_STEPS-1];
  assign data_o  = st_q[rpc_pkg::CORDIC_STEPS-1];

endmodule

FILE: hw/rtl/rpc_post.sv
module rpc_post (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rpc_pkg::rot_t data_i,
  output logic          valid_o,
  output rpc_pkg::out_t data_o
);

  localparam logic signed [rpc_pkg::ZW-1:0] ANG_HALF =
      rpc_pkg::ZW'(64'sd1 <<< (rpc_pkg::ANG_SHIFT - 1));
  localparam logic signed [rpc_pkg::PW-1:0] GAIN_HALF =
      rpc_pkg::PW'(64'sd1 <<< (rpc_pkg::GAIN_SHIFT - 1));

  // stage 1: partial products of the gain correction, angle rounding
  logic                                p1_v_q, p1_mode_q, p1_zero_q;
  logic signed [rpc_pkg::PH_W-1:0]     p1_phx_q, p1_phy_q;
  logic [rpc_pkg::PL_W-1:0]            p1_plx_q, p1_ply_q;
  logic signed [rpc_pkg::RND_W-1:0]    p1_ang_q;

  logic signed [rpc_pkg::GAIN_W:0]     gain_s;
  logic signed [rpc_pkg::PH_W-1:0]     phx_d, phy_d;
  logic [rpc_pkg::PL_W-1:0]            plx_d, ply_d;
  logic signed [rpc_pkg::ZW-1:0]       ang_r;
  logic signed [rpc_pkg::RND_W-1:0]    ang_d;

  always_comb begin
    gain_s = $signed({1'b0, rpc_pkg::INV_GAIN});
    phx_d  = rpc_pkg::PH_W'($signed(data_i.x[rpc_pkg::XW-1:rpc_pkg::SPLIT])) *
             rpc_pkg::PH_W'(gain_s);
    phy_d  = rpc_pkg::PH_W'($signed(data_i.y[rpc_pkg::XW-1:rpc_pkg::SPLIT])) *
             rpc_pkg::PH_W'(gain_s);
    plx_d  = rpc_pkg::PL_W'(data_i.x[rpc_pkg::SPLIT-1:0]) *
             rpc_pkg::PL_W'(rpc_pkg::INV_GAIN);
    ply_d  = rpc_pkg::PL_W'(data_i.y[rpc_pkg::SPLIT-1:0]) *
             rpc_pkg::PL_W'(rpc_pkg::INV_GAIN);
    ang_r  = (data_i.z + ANG_HALF) >>> rpc_pkg::ANG_SHIFT;
    ang_d  = rpc_pkg::RND_W'(ang_r);
  end

  // stage 2: sum partial products, round half up
  logic                                p2_v_q, p2_mode_q, p2_zero_q;
  logic signed [rpc_pkg::RND_W-1:0]    p2_rx_q, p2_ry_q, p2_ang_q;

  logic signed [rpc_pkg::PW-1:0]       px, py;
  logic signed [rpc_pkg::RND_W-1:0]    rx_d, ry_d;

  always_comb begin
    px = (rpc_pkg::PW'(p1_phx_q) <<< rpc_pkg::SPLIT)
       + $signed(rpc_pkg::PW'(p1_plx_q)) + GAIN_HALF;
    py = (rpc_pkg::PW'(p1_phy_q) <<< rpc_pkg::SPLIT)
       + $signed(rpc_pkg::PW'(p1_ply_q)) + GAIN_HALF;
    rx_d = rpc_pkg::RND_W'(px >>> rpc_pkg::GAIN_SHIFT);
    ry_d = rpc_pkg::RND_W'(py >>> rpc_pkg::GAIN_SHIFT);
  end

  // stage 3: clip to 32 bits
  logic                                p3_v_q;
  rpc_pkg::out_t                       p3_q, p3_d;
  rpc_pkg::sat_t                       sa, sb;

  always_comb begin
    sa = rpc_pkg::sat32(p2_rx_q);
    if (p2_mode_q == rpc_pkg::MODE_RECT) begin
      // zero vector has no direction, report angle zero
      sb = rpc_pkg::sat32(p2_zero_q ? '0 : p2_ang_q);
    end else begin
      sb = rpc_pkg::sat32(p2_ry_q);
    end
    p3_d.result_a  = sa.val;
    p3_d.result_b  = sb.val;
    p3_d.saturated = sa.sat | sb.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else if (en_i) begin
      p1_v_q <= valid_i;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_mode_q <= data_i.mode;
      p1_zero_q <= data_i.zero;
      p1_phx_q  <= phx_d;
      p1_phy_q  <= phy_d;
      p1_plx_q  <= plx_d;
      p1_ply_q  <= ply_d;
      p1_ang_q  <= ang_d;

      p2_mode_q <= p1_mode_q;
      p2_zero_q <= p1_zero_q;
      p2_rx_q   <= rx_d;
      p2_ry_q   <= ry_d;
      p2_ang_q  <= p1_ang_q;

      p3_q      <= p3_d;
    end
  end

  assign valid_o = p3_v_q;
  assign data_o  = p3_q;

endmodule
